// File: rtl/u8af_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to ASCII folder package
// Shared widths, limits, character codes, modes and the Latin-1 fold table.
// ----------------------------------------------------------------------------
`default_nettype none

package u8af_pkg;

    localparam int unsigned CAP_W = 13;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CHAR_W = 7;
    localparam int unsigned CNT_W = 2;

    localparam logic [CAP_W-1:0] MAX_CAPACITY = 13'd4096;
    localparam logic [CAP_W-1:0] RESET_CAPACITY = 13'd128;

    localparam logic [BYTE_W-1:0] BYTE_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_LEAD_C3 = 8'hC3;
    localparam logic [BYTE_W-1:0] BYTE_LEAD_E2 = 8'hE2;
    localparam logic [BYTE_W-1:0] BYTE_MID_80 = 8'h80;
    localparam logic [BYTE_W-1:0] BYTE_ELLIPSIS = 8'hA6;
    localparam logic [BYTE_W-1:0] BYTE_LQUOTE = 8'h98;
    localparam logic [BYTE_W-1:0] BYTE_RQUOTE = 8'h99;

    localparam logic [1:0] CONT_TAG = 2'b10;

    localparam logic [CHAR_W-1:0] CH_NUL = 7'h00;
    localparam logic [CHAR_W-1:0] CH_DOT = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_APOS = 7'h27;
    localparam logic [CHAR_W-1:0] CH_QUEST = 7'h3F;

    typedef enum logic [2:0] {
        MODE_READY = 3'd0,
        MODE_AFTER_C3 = 3'd1,
        MODE_AFTER_E2 = 3'd2,
        MODE_AFTER_E280 = 3'd3,
        MODE_SKIP = 3'd4
    } fold_mode_t;

    function automatic logic [CHAR_W-1:0] fold_latin(input logic [BYTE_W-1:0] b);
        logic [CHAR_W-1:0] ch;
        unique case (b)
            8'hA0, 8'hA2: ch = 7'h61;
            8'hA7: ch = 7'h63;
            8'hA8, 8'hA9, 8'hAA, 8'hAB: ch = 7'h65;
            8'hAE, 8'hAF: ch = 7'h69;
            8'hB4: ch = 7'h6F;
            8'hB9, 8'hBB: ch = 7'h75;
            8'h80, 8'h82: ch = 7'h41;
            8'h87: ch = 7'h43;
            8'h88, 8'h89, 8'h8A: ch = 7'h45;
            default: ch = CH_QUEST;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: rtl/utf8_to_ascii_folder.sv
// ----------------------------------------------------------------------------
// UTF-8 to ASCII folder
// Folds a zero-terminated UTF-8 byte stream to ASCII characters, one request
// per byte, up to three result requests per byte, limited by capacity.
// ----------------------------------------------------------------------------
// An accepted byte waits in the byte stage; its results are then registered
// in the result register. Throughput: one byte per cycle while the result
// register is free; a multi-result byte holds it until its last is taken.
// Reset: capacity 128, ready for a lead byte, count zero, both stages empty.
`default_nettype none

module utf8_to_ascii_folder (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [u8af_pkg::CAP_W-1:0]     cfg_wr_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [u8af_pkg::BYTE_W-1:0]    in_byte,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [u8af_pkg::CHAR_W-1:0]         char_out,
    output logic                                end_of_string
);

    logic [u8af_pkg::CAP_W-1:0]   capacity_reg;
    logic                         s1_valid_reg;
    logic [u8af_pkg::BYTE_W-1:0]  s1_byte_reg;
    u8af_pkg::fold_mode_t         mode_reg;
    u8af_pkg::fold_mode_t         mode_next;
    logic [u8af_pkg::CAP_W-1:0]   written_reg;
    logic [u8af_pkg::CAP_W-1:0]   written_next;
    logic [u8af_pkg::CNT_W-1:0]   pend_cnt_reg;
    logic [u8af_pkg::CHAR_W-1:0]  pend_char_reg;
    logic                         pend_eos_reg;

    logic [u8af_pkg::CAP_W-1:0]   cap_eff;
    logic [u8af_pkg::CAP_W:0]     cap_ext;
    logic [u8af_pkg::CAP_W:0]     written_ext;
    logic                         ok1;
    logic                         ok2;
    logic                         ok3;
    logic                         s1_advance;
    logic                         in_take;
    logic                         out_take;
    logic                         b_cont;
    u8af_pkg::fold_mode_t         lead_mode;
    logic                         lead_emit;
    logic [u8af_pkg::CNT_W-1:0]   res_cnt;
    logic [u8af_pkg::CHAR_W-1:0]  res_char;
    logic                         res_eos;

    assign cap_eff = (capacity_reg > u8af_pkg::MAX_CAPACITY) ? u8af_pkg::MAX_CAPACITY
                                                             : capacity_reg;
    assign cap_ext = {1'b0, cap_eff};
    assign written_ext = {1'b0, written_reg};
    assign ok1 = (written_ext + 14'd1) < cap_ext;
    assign ok2 = (written_ext + 14'd2) < cap_ext;
    assign ok3 = (written_ext + 14'd3) < cap_ext;

    assign out_valid = (pend_cnt_reg != 2'd0);
    assign char_out = pend_char_reg;
    assign end_of_string = pend_eos_reg;
    assign out_take = out_valid && out_ready;

    assign s1_advance = s1_valid_reg &&
                        ((pend_cnt_reg == 2'd0) || ((pend_cnt_reg == 2'd1) && out_ready));
    assign in_ready = !s1_valid_reg || s1_advance;
    assign in_take = in_valid && in_ready;

    assign b_cont = (s1_byte_reg[7:6] == u8af_pkg::CONT_TAG);

    always_comb
    begin
        lead_emit = 1'b0;
        priority if (!s1_byte_reg[7])
        begin
            lead_mode = u8af_pkg::MODE_READY;
            lead_emit = 1'b1;
        end
        else if (s1_byte_reg == u8af_pkg::BYTE_LEAD_C3)
        begin
            lead_mode = u8af_pkg::MODE_AFTER_C3;
        end
        else if (s1_byte_reg == u8af_pkg::BYTE_LEAD_E2)
        begin
            lead_mode = u8af_pkg::MODE_AFTER_E2;
        end
        else
        begin
            lead_mode = u8af_pkg::MODE_SKIP;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        res_cnt = 2'd0;
        res_char = s1_byte_reg[u8af_pkg::CHAR_W-1:0];
        res_eos = 1'b0;
        if (s1_byte_reg == u8af_pkg::BYTE_NUL)
        begin
            mode_next = u8af_pkg::MODE_READY;
            res_cnt = 2'd1;
            res_char = u8af_pkg::CH_NUL;
            res_eos = 1'b1;
        end
        else
        begin
            unique case (mode_reg)
                u8af_pkg::MODE_AFTER_C3:
                begin
                    mode_next = u8af_pkg::MODE_READY;
                    res_char = u8af_pkg::fold_latin(s1_byte_reg);
                    res_cnt = {1'b0, ok1};
                end
                u8af_pkg::MODE_AFTER_E2:
                begin
                    priority if (s1_byte_reg == u8af_pkg::BYTE_MID_80)
                    begin
                        mode_next = u8af_pkg::MODE_AFTER_E280;
                    end
                    else if (b_cont)
                    begin
                        mode_next = u8af_pkg::MODE_SKIP;
                    end
                    else
                    begin
                        mode_next = lead_mode;
                        res_cnt = {1'b0, lead_emit && ok1};
                    end
                end
                u8af_pkg::MODE_AFTER_E280:
                begin
                    mode_next = u8af_pkg::MODE_READY;
                    priority if (s1_byte_reg == u8af_pkg::BYTE_ELLIPSIS)
                    begin
                        res_char = u8af_pkg::CH_DOT;
                        res_cnt = {1'b0, ok1} + {1'b0, ok2} + {1'b0, ok3};
                    end
                    else if ((s1_byte_reg == u8af_pkg::BYTE_LQUOTE) ||
                             (s1_byte_reg == u8af_pkg::BYTE_RQUOTE))
                    begin
                        res_char = u8af_pkg::CH_APOS;
                        res_cnt = {1'b0, ok1};
                    end
                    else
                    begin
                        res_cnt = 2'd0;
                    end
                end
                u8af_pkg::MODE_SKIP:
                begin
                    if (!b_cont)
                    begin
                        mode_next = lead_mode;
                        res_cnt = {1'b0, lead_emit && ok1};
                    end
                end
                default:
                begin
                    mode_next = lead_mode;
                    res_cnt = {1'b0, lead_emit && ok1};
                end
            endcase
        end
        written_next = res_eos ? '0 : written_reg + {{(u8af_pkg::CAP_W-2){1'b0}}, res_cnt};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= u8af_pkg::RESET_CAPACITY;
            s1_valid_reg <= 1'b0;
            mode_reg <= u8af_pkg::MODE_READY;
            written_reg <= '0;
            pend_cnt_reg <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                mode_reg <= mode_next;
                written_reg <= written_next;
                pend_cnt_reg <= res_cnt;
            end
            else if (out_take)
            begin
                pend_cnt_reg <= pend_cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= in_byte;
        end
        if (s1_advance)
        begin
            pend_char_reg <= res_char;
            pend_eos_reg <= res_eos;
        end
    end

`ifndef SYNTH
    a_eos_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_string |-> (char_out == u8af_pkg::CH_NUL) && (pend_cnt_reg == 2'd1))
        else $error("end result not a single zero character");

    a_multi_is_dots: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_cnt_reg > 2'd1) |-> (char_out == u8af_pkg::CH_DOT) && !end_of_string)
        else $error("repeated result is not a dot");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        written_reg < u8af_pkg::MAX_CAPACITY)
        else $error("written count beyond capacity limit");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && (s1_byte_reg == u8af_pkg::BYTE_NUL) |=>
        (written_reg == '0) && (mode_reg == u8af_pkg::MODE_READY))
        else $error("terminator did not clear state");

    a_take_frees: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && s1_valid_reg |-> s1_advance && (pend_cnt_reg <= 2'd1))
        else $error("input taken while stage is blocked");
`endif

endmodule

`default_nettype wire
